FILE: sv/tcrp_pkg.sv
// shared types, constants and digit helpers for the reply parser
package tcrp_pkg;

	localparam int REPLY_LEN   = 19;
	localparam int ACK_LEN     = 6;
	localparam int MIN_LEN     = 4;
	localparam int BODY_BYTES  = 14;
	localparam int BODY_FIRST  = 3;
	localparam int STORE_TOP   = BODY_FIRST + BODY_BYTES - 1;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] START_CHAR = 8'h21;
	localparam logic [7:0] CR_CHAR    = 8'h0D;
	localparam logic [7:0] LF_CHAR    = 8'h0A;
	localparam logic [7:0] ZERO_CHAR  = 8'h30;
	localparam logic [7:0] ONE_CHAR   = 8'h31;
	localparam logic [7:0] NINE_CHAR  = 8'h39;

	localparam logic [3:0] STATUS_OK  = 4'd0;
	localparam logic [3:0] STATUS_OFF = 4'd3;
	localparam logic [3:0] STATUS_BAD = 4'd4;
	localparam logic [1:0] CHAN_MAX   = 2'd2;

	// body byte positions, counted from frame byte three
	localparam int POS_CURRENT = 0;
	localparam int POS_SET_ONE = 3;
	localparam int POS_SET_TWO = 6;
	localparam int POS_SET_THR = 9;
	localparam int POS_CHANNEL = 12;
	localparam int POS_STATUS  = 13;

	typedef enum logic [1:0] {
		KIND_REPLY = 2'd0,
		KIND_ACK   = 2'd1,
		KIND_BAD   = 2'd2
	} frame_kind_t;

	typedef struct packed {
		frame_kind_t                  kind;
		logic [BODY_BYTES-1:0][7:0]   body;
	} frame_desc_t;

	typedef struct packed {
		logic        valid;
		frame_desc_t desc;
	} desc_push_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= ZERO_CHAR) && (c <= NINE_CHAR);
	endfunction

	function automatic logic [3:0] digit_val(input logic [7:0] c);
		logic [7:0] d;
		d = c - ZERO_CHAR;
		return is_digit(c) ? d[3:0] : 4'd0;
	endfunction

	// c2 is the hundreds digit; any non-digit makes the field zero
	function automatic logic [9:0] three_digits(input logic [7:0] c2, input logic [7:0] c1,
			input logic [7:0] c0);
		logic [9:0] h;
		logic [9:0] t;
		logic [9:0] u;
		h = 10'(digit_val(c2));
		t = 10'(digit_val(c1));
		u = 10'(digit_val(c0));
		if (is_digit(c2) && is_digit(c1) && is_digit(c0)) begin
			return h * 10'd100 + t * 10'd10 + u;
		end
		return 10'd0;
	endfunction

endpackage

FILE: sv/tcrp_front.sv
// front end: frames incoming bytes and hands completed frames to the queue
module tcrp_front
	import tcrp_pkg::*;
#(
	parameter int FRAME_BYTES = 19
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	input  logic [7:0] rx_byte,
	output desc_push_t push
);

	localparam int CW = $clog2(FRAME_BYTES + 1);

	logic          in_frame_q;
	logic [CW-1:0] count_q;
	logic          last_cr_q;
	logic [7:0]    store_q [1:STORE_TOP];

	logic          is_start;
	logic          overrun;
	logic          frame_end;
	logic [CW-1:0] next_count;
	logic          id_ok;

	assign is_start   = rx_byte == START_CHAR;
	assign overrun    = count_q >= CW'(FRAME_BYTES);
	assign next_count = count_q + 1'b1;
	assign frame_end  = byte_valid && !is_start && in_frame_q && !overrun &&
		(rx_byte == LF_CHAR) && last_cr_q;
	assign id_ok      = (store_q[1] == ZERO_CHAR) && (store_q[2] == ONE_CHAR);

	always_comb begin
		push.valid = frame_end && (next_count >= CW'(MIN_LEN));
		if (next_count == CW'(REPLY_LEN) && id_ok) begin
			push.desc.kind = KIND_REPLY;
		end else if (next_count == CW'(ACK_LEN) && id_ok) begin
			push.desc.kind = KIND_ACK;
		end else begin
			push.desc.kind = KIND_BAD;
		end
		for (int i = 0; i < BODY_BYTES; i++) begin
			push.desc.body[i] = store_q[i + BODY_FIRST];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			count_q    <= '0;
			last_cr_q  <= 1'b0;
		end else if (byte_valid) begin
			if (is_start) begin
				in_frame_q <= 1'b1;
				count_q    <= CW'(1);
				last_cr_q  <= 1'b0;
			end else if (in_frame_q) begin
				if (overrun || frame_end) begin
					in_frame_q <= 1'b0;
					count_q    <= '0;
				end else begin
					count_q   <= next_count;
					last_cr_q <= rx_byte == CR_CHAR;
				end
			end
		end
	end

	// only the bytes the decoder looks at are kept
	always_ff @(posedge clk) begin
		if (byte_valid && in_frame_q && !is_start && !overrun) begin
			for (int i = 1; i <= STORE_TOP; i++) begin
				if (count_q == CW'(i)) begin
					store_q[i] <= rx_byte;
				end
			end
		end
	end

endmodule

FILE: sv/tcrp_queue.sv
// short queue of completed frame descriptors between front and back
module tcrp_queue
	import tcrp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  desc_push_t  push,
	input  logic        pop,
	output logic        not_empty,
	output logic        full,
	output frame_desc_t head
);

	frame_desc_t       mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] fill_q;
	logic              do_push;
	logic              do_pop;

	assign not_empty = fill_q != '0;
	assign full      = fill_q == QCNT_W'(QUEUE_DEPTH);
	assign do_push   = push.valid && !full;
	assign do_pop    = pop && not_empty;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.desc;
		end
	end

endmodule

FILE: sv/tcrp_back.sv
// back end: decodes frames, keeps the held values and drives the result register
module tcrp_back
	import tcrp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  frame_desc_t head,
	output logic        pop,
	input  logic        out_ready,
	output logic        out_valid,
	output logic [3:0]  ctrl_status,
	output logic [9:0]  current_temp,
	output logic [9:0]  set_temp_one,
	output logic [9:0]  set_temp_two,
	output logic [9:0]  set_temp_three,
	output logic [1:0]  heat_channel,
	output logic        values_updated
);

	logic [3:0] held_status_q;
	logic [9:0] held_current_q;
	logic [9:0] held_set_one_q;
	logic [9:0] held_set_two_q;
	logic [9:0] held_set_thr_q;
	logic [1:0] held_channel_q;
	logic       out_valid_q;

	logic [3:0] status_d;
	logic [9:0] current_d;
	logic [9:0] set_one_d;
	logic [9:0] set_two_d;
	logic [9:0] set_thr_d;
	logic [1:0] channel_d;
	logic       updated_d;
	logic [3:0] chan_digit;

	assign pop       = head_valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign chan_digit = digit_val(head.body[POS_CHANNEL]);

	always_comb begin
		status_d  = held_status_q;
		current_d = held_current_q;
		set_one_d = held_set_one_q;
		set_two_d = held_set_two_q;
		set_thr_d = held_set_thr_q;
		channel_d = held_channel_q;
		updated_d = 1'b0;
		unique case (head.kind)
			KIND_REPLY: begin
				status_d = digit_val(head.body[POS_STATUS]);
				if (status_d == STATUS_OK) begin
					current_d = three_digits(head.body[POS_CURRENT],
						head.body[POS_CURRENT + 1], head.body[POS_CURRENT + 2]);
					set_one_d = three_digits(head.body[POS_SET_ONE],
						head.body[POS_SET_ONE + 1], head.body[POS_SET_ONE + 2]);
					set_two_d = three_digits(head.body[POS_SET_TWO],
						head.body[POS_SET_TWO + 1], head.body[POS_SET_TWO + 2]);
					set_thr_d = three_digits(head.body[POS_SET_THR],
						head.body[POS_SET_THR + 1], head.body[POS_SET_THR + 2]);
					channel_d = (chan_digit > 4'(CHAN_MAX)) ? 2'd0 : chan_digit[1:0];
					updated_d = 1'b1;
				end
			end
			KIND_ACK: begin
				status_d = STATUS_OK;
			end
			default: begin
				status_d = STATUS_BAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_status_q  <= STATUS_OFF;
			held_current_q <= '0;
			held_set_one_q <= '0;
			held_set_two_q <= '0;
			held_set_thr_q <= '0;
			held_channel_q <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (pop) begin
				held_status_q  <= status_d;
				held_current_q <= current_d;
				held_set_one_q <= set_one_d;
				held_set_two_q <= set_two_d;
				held_set_thr_q <= set_thr_d;
				held_channel_q <= channel_d;
				out_valid_q    <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ctrl_status    <= status_d;
			current_temp   <= current_d;
			set_temp_one   <= set_one_d;
			set_temp_two   <= set_two_d;
			set_temp_three <= set_thr_d;
			heat_channel   <= channel_d;
			values_updated <= updated_d;
		end
	end

endmodule

FILE: sv/temp_controller_reply_parser.sv
// top level of the temperature controller reply parser
//
// s_tdata carries one received serial byte per transfer. A '!' opens a frame and
// CR LF closes it; each closed frame of at least four bytes gives one transfer
// on the master side with the status and the held temperature values, while
// frames longer than FRAME_BYTES are dropped without a result.
// The closing LF pushes its frame's descriptor into the queue, and the
// decoder pops it into the result register behind m_tvalid when free.
// Throughput: one byte per cycle on the slave side while s_tready is high;
// one frame per cycle moves from queue to result while m_tready is high.
// A two-entry descriptor queue sits between the byte framer and the decoder,
// so bytes keep flowing while a result waits. s_tready drops only when the
// queue is full, which takes two unread results plus a stalled output.
// Reset clears the framer, empties the queue, sets the held status to off (3)
// and the temperatures and channel to zero.
module temp_controller_reply_parser
	import tcrp_pkg::*;
#(
	parameter int FRAME_BYTES = 19
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [3:0] ctrl_status, [13:4] current_temp,
	                               // [23:14] set_temp_one, [33:24] set_temp_two,
	                               // [43:34] set_temp_three, [45:44] heat_channel
	output logic [0:0]  m_tuser    // [0] values_updated
);

	desc_push_t  front_push;
	frame_desc_t q_head;
	logic        q_not_empty;
	logic        q_full;
	logic        q_pop;
	logic        byte_xfer;

	logic [3:0]  ctrl_status;
	logic [9:0]  current_temp;
	logic [9:0]  set_temp_one;
	logic [9:0]  set_temp_two;
	logic [9:0]  set_temp_three;
	logic [1:0]  heat_channel;
	logic        values_updated;

	assign s_tready  = !q_full;
	assign byte_xfer = s_tvalid && s_tready;

	tcrp_front #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_xfer),
		.rx_byte   (s_tdata),
		.push      (front_push)
	);

	tcrp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (front_push),
		.pop      (q_pop),
		.not_empty(q_not_empty),
		.full     (q_full),
		.head     (q_head)
	);

	tcrp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (q_not_empty),
		.head          (q_head),
		.pop           (q_pop),
		.out_ready     (m_tready),
		.out_valid     (m_tvalid),
		.ctrl_status   (ctrl_status),
		.current_temp  (current_temp),
		.set_temp_one  (set_temp_one),
		.set_temp_two  (set_temp_two),
		.set_temp_three(set_temp_three),
		.heat_channel  (heat_channel),
		.values_updated(values_updated)
	);

	assign m_tdata = {2'b00, heat_channel, set_temp_three, set_temp_two, set_temp_one,
		current_temp, ctrl_status};
	assign m_tuser = values_updated;

	// a completed frame must always find room in the queue
	assert property (@(posedge clk) disable iff (!arst_n) !(front_push.valid && q_full))
		else $error("frame descriptor pushed into a full queue");

	assert property (@(posedge clk) disable iff (!arst_n) q_pop |-> q_not_empty)
		else $error("decoder popped an empty queue");

	// fresh values only come from a reply with normal status
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[3:0] == STATUS_OK))
		else $error("values updated with non-normal status");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[45:44] <= CHAN_MAX))
		else $error("heating channel out of range");

endmodule

FILE: tb/tb.sv
// self-checking testbench for the temperature controller reply parser
`timescale 1ns / 100ps

module tb;
	import tcrp_pkg::*;

	localparam int FRAME_LIMIT  = 19;
	localparam int ITEM_TARGET  = 1160;
	localparam int STEADY_BYTES = 300;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;

	// byte offsets inside a full reply
	localparam int AT_CURRENT   = BODY_FIRST + POS_CURRENT;
	localparam int AT_SET_ONE   = BODY_FIRST + POS_SET_ONE;
	localparam int AT_SET_TWO   = BODY_FIRST + POS_SET_TWO;
	localparam int AT_SET_THREE = BODY_FIRST + POS_SET_THR;
	localparam int AT_CHANNEL   = BODY_FIRST + POS_CHANNEL;
	localparam int AT_STATUS    = BODY_FIRST + POS_STATUS;

	typedef struct packed {
		logic [3:0] status;
		logic [9:0] current;
		logic [9:0] set_one;
		logic [9:0] set_two;
		logic [9:0] set_three;
		logic [1:0] channel;
		logic       updated;
	} reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [0:0]  m_tuser;

	// predictor state
	logic       in_frame;
	int         byte_count;
	logic [7:0] rx_frame [0:31];
	logic [3:0] held_status;
	logic [9:0] held_current;
	logic [9:0] held_set [0:2];
	logic [1:0] held_channel;

	reply_t     expected_replies [$];
	logic [7:0] outgoing [$];
	int         failures = 0;
	int         bytes_sent = 0;
	bit         steady = 1'b0;
	bit         hold_request = 1'b0;

	temp_controller_reply_parser #(
		.FRAME_BYTES(FRAME_LIMIT)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// n ascii digits from the current frame, zero when any is not a digit
	function automatic int field_value(input int pos, input int n);
		int v;
		v = 0;
		for (int i = 0; i < n; i++) begin
			if (rx_frame[pos + i] < ZERO_CHAR || rx_frame[pos + i] > NINE_CHAR) begin
				return 0;
			end
			v = v * 10 + int'(rx_frame[pos + i] - ZERO_CHAR);
		end
		return v;
	endfunction

	// frame tracking and decode for one accepted byte
	function automatic void parse_reply_byte(input logic [7:0] b);
		reply_t r;
		logic   is_id;
		int     chan;
		if (b == START_CHAR) begin
			in_frame = 1'b1;
			rx_frame[0] = b;
			byte_count = 1;
			return;
		end
		if (!in_frame) begin
			return;
		end
		if (byte_count >= FRAME_LIMIT) begin
			in_frame = 1'b0;
			byte_count = 0;
			return;
		end
		rx_frame[byte_count] = b;
		byte_count++;
		if (b != LF_CHAR || rx_frame[byte_count - 2] != CR_CHAR) begin
			return;
		end
		in_frame = 1'b0;
		if (byte_count < MIN_LEN) begin
			byte_count = 0;
			return;
		end
		is_id = rx_frame[0] == START_CHAR && rx_frame[1] == ZERO_CHAR &&
			rx_frame[2] == ONE_CHAR;
		r.updated = 1'b0;
		if (byte_count == REPLY_LEN && is_id) begin
			held_status = 4'(field_value(AT_STATUS, 1));
			if (held_status == STATUS_OK) begin
				held_current = 10'(field_value(AT_CURRENT, 3));
				held_set[0] = 10'(field_value(AT_SET_ONE, 3));
				held_set[1] = 10'(field_value(AT_SET_TWO, 3));
				held_set[2] = 10'(field_value(AT_SET_THREE, 3));
				chan = field_value(AT_CHANNEL, 1);
				held_channel = (chan > int'(CHAN_MAX)) ? 2'd0 : 2'(chan);
				r.updated = 1'b1;
			end
		end else if (byte_count == ACK_LEN && is_id) begin
			held_status = STATUS_OK;
		end else begin
			held_status = STATUS_BAD;
		end
		byte_count = 0;
		r.status = held_status;
		r.current = held_current;
		r.set_one = held_set[0];
		r.set_two = held_set[1];
		r.set_three = held_set[2];
		r.channel = held_channel;
		expected_replies.push_back(r);
	endfunction

	task automatic send_byte(input logic [7:0] b);
		while (!steady && $urandom_range(0, 99) < 35) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		parse_reply_byte(b);
		bytes_sent++;
	endtask

	task automatic send_outgoing();
		foreach (outgoing[i]) begin
			send_byte(outgoing[i]);
		end
		outgoing.delete();
	endtask

	task automatic wait_for_replies();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_replies.size() != 0) begin
			@(posedge clk);
		end
	endtask

	function automatic void add_number(input int v, input int n);
		int d;
		d = 1;
		for (int i = 1; i < n; i++) begin
			d *= 10;
		end
		for (int i = 0; i < n; i++) begin
			outgoing.push_back(ZERO_CHAR + 8'((v / d) % 10));
			d /= 10;
		end
	endfunction

	function automatic void add_reply(input int cur, input int s1, input int s2, input int s3,
			input logic [7:0] chan, input logic [7:0] stat);
		outgoing.push_back(START_CHAR);
		outgoing.push_back(ZERO_CHAR);
		outgoing.push_back(ONE_CHAR);
		add_number(cur, 3);
		add_number(s1, 3);
		add_number(s2, 3);
		add_number(s3, 3);
		outgoing.push_back(chan);
		outgoing.push_back(stat);
		outgoing.push_back(CR_CHAR);
		outgoing.push_back(LF_CHAR);
	endfunction

	function automatic void add_frame_end();
		outgoing.push_back(CR_CHAR);
		outgoing.push_back(LF_CHAR);
	endfunction

	function automatic int random_temp();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 999;
			default: return $urandom_range(0, 999);
		endcase
	endfunction

	task automatic compare_field(input string what, input int want, input int got);
		if (want != got) begin
			failures++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
		end
	endtask

	// result side: checks each transfer and drives m_tready
	initial begin
		reply_t want;
		int     hold_left;
		hold_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (expected_replies.size() == 0) begin
					failures++;
					$display("%0t: unexpected result, expected none, actual %h/%b",
						$time, m_tdata, m_tuser);
				end else begin
					want = expected_replies.pop_front();
					compare_field("ctrl_status", want.status, m_tdata[3:0]);
					compare_field("current_temp", want.current, m_tdata[13:4]);
					compare_field("set_temp_one", want.set_one, m_tdata[23:14]);
					compare_field("set_temp_two", want.set_two, m_tdata[33:24]);
					compare_field("set_temp_three", want.set_three, m_tdata[43:34]);
					compare_field("heat_channel", want.channel, m_tdata[45:44]);
					compare_field("values_updated", want.updated, m_tuser[0]);
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
				m_tready <= 1'b0;
			end else begin
				m_tready <= steady || ($urandom_range(0, 99) >= 35);
			end
		end
	end

	task automatic test_basic_frames();
		// full-scale and zero values, channel at its top
		add_reply(999, 999, 999, 999, ZERO_CHAR + 8'd2, ZERO_CHAR);
		add_reply(0, 0, 0, 0, ZERO_CHAR, ZERO_CHAR);
		// channel above two reads as zero
		add_reply(123, 456, 789, 5, NINE_CHAR, ZERO_CHAR);
		// nonzero status only touches the status
		add_reply(111, 222, 333, 444, ONE_CHAR, ZERO_CHAR + 8'd2);
		add_reply(321, 654, 987, 12, ONE_CHAR, NINE_CHAR);
		send_outgoing();
		// non-digit in a temperature and in the status digit
		add_reply(135, 246, 357, 468, ONE_CHAR, ZERO_CHAR);
		outgoing[AT_CURRENT + 1] = "A";
		outgoing[AT_STATUS] = "x";
		send_outgoing();
		// acknowledgement, then frames that decode as bad
		outgoing = '{START_CHAR, ZERO_CHAR, ONE_CHAR, "K", CR_CHAR, LF_CHAR};
		send_outgoing();
		outgoing = '{START_CHAR, ZERO_CHAR, ZERO_CHAR + 8'd2, "K", CR_CHAR, LF_CHAR};
		send_outgoing();
		outgoing = '{START_CHAR, "x", CR_CHAR, LF_CHAR};
		send_outgoing();
		add_reply(100, 200, 300, 400, ONE_CHAR, ZERO_CHAR);
		outgoing[2] = ZERO_CHAR;
		send_outgoing();
		// too short, bytes outside a frame
		outgoing = '{START_CHAR, CR_CHAR, LF_CHAR, 8'h00, 8'hFF, CR_CHAR, LF_CHAR};
		send_outgoing();
		// restart inside a frame
		outgoing = '{START_CHAR, ZERO_CHAR, ONE_CHAR, ONE_CHAR, ONE_CHAR};
		add_reply(500, 501, 502, 503, ONE_CHAR, ZERO_CHAR);
		send_outgoing();
		// overlong frame is dropped, later CR LF is ignored
		outgoing.push_back(START_CHAR);
		repeat (FRAME_LIMIT) outgoing.push_back("A");
		add_frame_end();
		outgoing = {outgoing, START_CHAR, ZERO_CHAR, ONE_CHAR, 8'h7F, CR_CHAR, LF_CHAR};
		send_outgoing();
		wait_for_replies();
	endtask

	task automatic test_output_backpressure();
		hold_request = 1'b1;
		repeat (16) begin
			outgoing = '{START_CHAR, 8'($urandom_range(65, 90)), CR_CHAR, LF_CHAR};
			send_outgoing();
		end
		add_reply(random_temp(), random_temp(), random_temp(), random_temp(),
			ZERO_CHAR + 8'($urandom_range(0, 9)), ZERO_CHAR);
		send_outgoing();
		wait_for_replies();
	endtask

	task automatic test_random_traffic();
		int first;
		int sel;
		int n;
		first = bytes_sent;
		steady = 1'b1;
		while (bytes_sent - first < ITEM_TARGET) begin
			if (bytes_sent - first >= STEADY_BYTES) begin
				steady = 1'b0;
			end
			sel = $urandom_range(0, 99);
			if (sel < 45) begin
				add_reply(random_temp(), random_temp(), random_temp(), random_temp(),
					ZERO_CHAR + 8'($urandom_range(0, 9)), ZERO_CHAR);
			end else if (sel < 55) begin
				add_reply(random_temp(), random_temp(), random_temp(), random_temp(),
					ZERO_CHAR + 8'($urandom_range(0, 9)),
					ZERO_CHAR + 8'($urandom_range(1, 9)));
			end else if (sel < 63) begin
				outgoing = '{START_CHAR, ZERO_CHAR, ONE_CHAR, 8'($urandom_range(0, 255))};
				add_frame_end();
			end else if (sel < 71) begin
				outgoing.push_back(START_CHAR);
				n = $urandom_range(1, 16);
				repeat (n) outgoing.push_back(8'($urandom_range(0, 255)));
				add_frame_end();
			end else if (sel < 76) begin
				outgoing.push_back(START_CHAR);
				n = $urandom_range(FRAME_LIMIT, FRAME_LIMIT + 5);
				repeat (n) outgoing.push_back(8'($urandom_range(48, 90)));
				add_frame_end();
			end else if (sel < 80) begin
				outgoing = '{START_CHAR, CR_CHAR, LF_CHAR};
			end else if (sel < 88) begin
				n = $urandom_range(1, 6);
				repeat (n) outgoing.push_back(8'($urandom_range(0, 255)));
			end else if (sel < 93) begin
				outgoing = '{START_CHAR, ZERO_CHAR, ONE_CHAR};
				add_number($urandom_range(0, 999), 3);
				add_reply(random_temp(), random_temp(), random_temp(), random_temp(),
					ZERO_CHAR + 8'($urandom_range(0, 9)), ZERO_CHAR);
			end else begin
				// one corrupted byte anywhere in the body
				add_reply(random_temp(), random_temp(), random_temp(), random_temp(),
					ZERO_CHAR + 8'($urandom_range(0, 9)), ZERO_CHAR);
				outgoing[$urandom_range(AT_CURRENT, AT_STATUS)] = 8'($urandom_range(0, 255));
			end
			send_outgoing();
			if ($urandom_range(0, 49) == 0) begin
				wait_for_replies();
			end
		end
		steady = 1'b0;
		wait_for_replies();
	endtask

	initial begin
		in_frame = 1'b0;
		byte_count = 0;
		held_status = STATUS_OFF;
		held_current = '0;
		held_set = '{default: '0};
		held_channel = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_frames();
		test_output_backpressure();
		test_random_traffic();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0 && expected_replies.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

FILE: filelist.f
sv/tcrp_pkg.sv
sv/tcrp_front.sv
sv/tcrp_queue.sv
sv/tcrp_back.sv
sv/temp_controller_reply_parser.sv
tb/tb.sv
